// ===== rtl/core/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat send window.
// No dependencies; every other file in rtl/core uses this package.
package srsw_pkg;

   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = 6;
   localparam int SLOT_W      = 34;
   localparam int CSR_IDX_W   = 2;

   localparam logic [1:0] ACT_SEND  = 2'd0;
   localparam logic [1:0] ACT_ACK   = 2'd1;
   localparam logic [1:0] ACT_SLIDE = 2'd2;

   localparam logic [1:0] KIND_NEW    = 2'd0;
   localparam logic [1:0] KIND_RESEND = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] ST_NOT_SENT = 2'd0;
   localparam logic [1:0] ST_AWAITING = 2'd1;
   localparam logic [1:0] ST_DONE     = 2'd2;

   localparam logic [1:0] ACK_TYPE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SEGMENTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS     = 2'd2;

   localparam logic [5:0]  WINDOW_SIZE_RST = 6'd16;
   localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  pkt_type;
      logic [31:0] ack_seq;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] seq_num;
      logic [31:0] window_base;
      logic        complete;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACK_RD,
      S_ACK_WR,
      S_SEND_RD,
      S_SEND_EX,
      S_SCAN_RD,
      S_SCAN_EX,
      S_COPY_RD,
      S_COPY_EX,
      S_CLEAR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic rd_ack;
      logic send_step;
      logic ack_wr;
      logic scan_step;
      logic latch_k;
      logic copy_step;
      logic clear;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic idx_lt_n;
      logic idx_lt_w;
      logic cnt_lt_max;
      logic tx;
      logic st_done;
      logic ack_hit;
      logic idx_nz;
      logic out_free;
      logic pend_vld;
   } sts_type;

endpackage

// ===== rtl/core/srsw_ctrl.sv =====
// Sequencer for the send window: walks slots one at a time for each pass.
// Depends on srsw_pkg; drives srsw_dp through cmd_type, reads sts_type.
module srsw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_action,
   output logic                req_ready,
   input  srsw_pkg::sts_type   sts,
   output srsw_pkg::cmd_type   cmd
);

   srsw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srsw_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         srsw_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_action)
                  srsw_pkg::ACT_SEND:  state_in = srsw_pkg::S_SEND_RD;
                  srsw_pkg::ACT_ACK:   state_in = srsw_pkg::S_ACK_RD;
                  srsw_pkg::ACT_SLIDE: state_in = srsw_pkg::S_SCAN_RD;
                  default:             state_in = srsw_pkg::S_FINISH;
               endcase
            end
         end
         srsw_pkg::S_ACK_RD: begin
            if (sts.ack_hit) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_ack = 1'b1;
               state_in   = srsw_pkg::S_ACK_WR;
            end else begin
               state_in = srsw_pkg::S_FINISH;
            end
         end
         srsw_pkg::S_ACK_WR: begin
            cmd.ack_wr = 1'b1;
            state_in   = srsw_pkg::S_FINISH;
         end
         srsw_pkg::S_SEND_RD: begin
            if (sts.idx_lt_n && sts.cnt_lt_max) begin
               cmd.rd_en = 1'b1;
               state_in  = srsw_pkg::S_SEND_EX;
            end else begin
               state_in = srsw_pkg::S_FINISH;
            end
         end
         srsw_pkg::S_SEND_EX: begin
            // hold while a pending result cannot move to the output
            if (!(sts.tx && sts.pend_vld && !sts.out_free)) begin
               cmd.send_step = 1'b1;
               state_in      = srsw_pkg::S_SEND_RD;
            end
         end
         srsw_pkg::S_SCAN_RD: begin
            if (sts.idx_lt_n) begin
               cmd.rd_en = 1'b1;
               state_in  = srsw_pkg::S_SCAN_EX;
            end else begin
               cmd.latch_k = 1'b1;
               state_in    = sts.idx_nz ? srsw_pkg::S_COPY_RD : srsw_pkg::S_FINISH;
            end
         end
         srsw_pkg::S_SCAN_EX: begin
            if (sts.st_done) begin
               cmd.scan_step = 1'b1;
               state_in      = srsw_pkg::S_SCAN_RD;
            end else begin
               cmd.latch_k = 1'b1;
               state_in    = sts.idx_nz ? srsw_pkg::S_COPY_RD : srsw_pkg::S_FINISH;
            end
         end
         srsw_pkg::S_COPY_RD: begin
            if (sts.idx_lt_w) begin
               cmd.rd_en = 1'b1;
               state_in  = srsw_pkg::S_COPY_EX;
            end else begin
               state_in = srsw_pkg::S_CLEAR;
            end
         end
         srsw_pkg::S_COPY_EX: begin
            cmd.copy_step = 1'b1;
            state_in      = srsw_pkg::S_COPY_RD;
         end
         srsw_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = srsw_pkg::S_FINISH;
         end
         srsw_pkg::S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = srsw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srsw_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/srsw_dp.sv =====
// Datapath for the send window: config registers, slot memory with valid
// bits, window base, counters, pending result and output register. Uses srsw_pkg.
module srsw_dp #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata,
   input  srsw_pkg::req_type                req_data,
   input  srsw_pkg::cmd_type                cmd,
   output srsw_pkg::sts_type                sts,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output srsw_pkg::rsp_type                rsp_data
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam logic [6:0] WMAX7 = 7'(WINDOW_MAX);

   logic [5:0]                   win_size_ff;
   logic [31:0]                  total_ff;
   logic [15:0]                  timeout_ff;
   logic [31:0]                  base_ff;
   srsw_pkg::req_type            req_ff;
   logic [CW-1:0]                n_ff, w_ff, idx_ff, k_ff;
   logic [srsw_pkg::CNT_W-1:0]   cnt_ff;
   logic [srsw_pkg::SLOT_W-1:0]  slot_mem [WINDOW_MAX];
   logic [srsw_pkg::SLOT_W-1:0]  rd_data_ff;
   logic                         rd_vld_ff;
   logic [WINDOW_MAX-1:0]        vld_ff, vld_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   srsw_pkg::rsp_type            rsp_data_ff;
   logic                         pend_vld_ff;
   srsw_pkg::rsp_type            pend_ff;

   logic [6:0]                   w7;
   logic [CW-1:0]                n_calc;
   logic [31:0]                  left;
   logic [31:0]                  ack_diff;
   logic [AW-1:0]                rd_addr;
   logic [srsw_pkg::SLOT_W-1:0]  slot_eff;
   logic [1:0]                   slot_st;
   logic [31:0]                  slot_tm;
   logic [31:0]                  age;
   logic                         tx;
   logic [CW-1:0]                copy_dst;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [srsw_pkg::SLOT_W-1:0]  wr_data;
   logic                         complete;
   srsw_pkg::rsp_type            new_res, stat_res, pend_last;
   logic                         push_out;

   // effective window and active slot count
   always_comb begin
      if (win_size_ff == 6'd0) begin
         w7 = 7'd1;
      end else if ({1'b0, win_size_ff} > WMAX7) begin
         w7 = WMAX7;
      end else begin
         w7 = {1'b0, win_size_ff};
      end
      left = total_ff - base_ff;
      if (base_ff >= total_ff) begin
         n_calc = '0;
      end else if (left < {{(32-CW){1'b0}}, w7[CW-1:0]}) begin
         n_calc = left[CW-1:0];
      end else begin
         n_calc = w7[CW-1:0];
      end
   end

   assign ack_diff = req_ff.ack_seq - base_ff;
   assign rd_addr  = cmd.rd_ack ? ack_diff[AW-1:0] : idx_ff[AW-1:0];
   assign slot_eff = rd_vld_ff ? rd_data_ff : '0;
   assign slot_st  = slot_eff[srsw_pkg::SLOT_W-1 -: 2];
   assign slot_tm  = slot_eff[31:0];
   assign age      = req_ff.now_ms - slot_tm;
   assign tx       = (slot_st == srsw_pkg::ST_NOT_SENT) ||
                     ((slot_st == srsw_pkg::ST_AWAITING) && (age > {16'd0, timeout_ff}));
   assign copy_dst = idx_ff - k_ff;
   assign complete = (base_ff == total_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = {srsw_pkg::ST_AWAITING, req_ff.now_ms};
      if (cmd.send_step && tx) begin
         wr_en = 1'b1;
      end else if (cmd.ack_wr) begin
         wr_en   = 1'b1;
         wr_addr = ack_diff[AW-1:0];
         wr_data = {srsw_pkg::ST_DONE, slot_tm};
      end else if (cmd.copy_step) begin
         wr_en   = 1'b1;
         wr_addr = copy_dst[AW-1:0];
         wr_data = slot_eff;
      end
   end

   always_comb begin
      new_res.kind        = (slot_st == srsw_pkg::ST_NOT_SENT) ?
                            srsw_pkg::KIND_NEW : srsw_pkg::KIND_RESEND;
      new_res.seq_num     = base_ff + {{(32-CW){1'b0}}, idx_ff};
      new_res.window_base = base_ff;
      new_res.complete    = complete;
      new_res.last        = 1'b0;

      stat_res.kind        = srsw_pkg::KIND_STATUS;
      stat_res.seq_num     = '0;
      stat_res.window_base = base_ff;
      stat_res.complete    = complete;
      stat_res.last        = 1'b1;

      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   assign push_out = cmd.finish || (cmd.send_step && tx && pend_vld_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (push_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   // valid bits: set on write, cleared over the refilled top of the window
   always_comb begin
      vld_in = vld_ff;
      for (int j = 0; j < WINDOW_MAX; j++) begin
         if (wr_en && (AW'(j) == wr_addr)) begin
            vld_in[j] = 1'b1;
         end
         if (cmd.clear && (CW'(j) >= (w_ff - k_ff)) && (CW'(j) < w_ff)) begin
            vld_in[j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (push_out) begin
         rsp_data_ff <= cmd.finish ? (pend_vld_ff ? pend_last : stat_res) : pend_ff;
      end
      if (cmd.send_step && tx) begin
         pend_ff <= new_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= srsw_pkg::WINDOW_SIZE_RST;
         total_ff     <= '0;
         timeout_ff   <= srsw_pkg::TIMEOUT_MS_RST;
         base_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         n_ff         <= '0;
         w_ff         <= '0;
         idx_ff       <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               srsw_pkg::CSR_WINDOW_SIZE:    win_size_ff <= csr_wdata[5:0];
               srsw_pkg::CSR_TOTAL_SEGMENTS: total_ff    <= csr_wdata;
               srsw_pkg::CSR_TIMEOUT_MS:     timeout_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            n_ff   <= n_calc;
            w_ff   <= w7[CW-1:0];
            idx_ff <= '0;
            k_ff   <= '0;
            cnt_ff <= '0;
         end
         if (cmd.send_step || cmd.scan_step || cmd.copy_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.send_step && tx) begin
            cnt_ff      <= cnt_ff + 1'b1;
            pend_vld_ff <= 1'b1;
         end
         if (cmd.finish) begin
            pend_vld_ff <= 1'b0;
         end
         if (cmd.latch_k) begin
            k_ff <= idx_ff;
         end
         if (cmd.clear) begin
            base_ff <= base_ff + {{(32-CW){1'b0}}, k_ff};
         end
      end
   end

   always_comb begin
      sts.idx_lt_n   = idx_ff < n_ff;
      sts.idx_lt_w   = idx_ff < w_ff;
      sts.cnt_lt_max = cnt_ff < srsw_pkg::CNT_W'(srsw_pkg::MAX_RESULTS);
      sts.tx         = tx;
      sts.st_done    = (slot_st == srsw_pkg::ST_DONE);
      sts.ack_hit    = (req_ff.pkt_type == srsw_pkg::ACK_TYPE) &&
                       (req_ff.ack_seq >= base_ff) &&
                       (ack_diff < {{(32-CW){1'b0}}, w_ff});
      sts.idx_nz     = (idx_ff != '0);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.pend_vld   = pend_vld_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/selective_repeat_send_window_unit.sv =====
// Selective-repeat send window, top level: sequencer plus datapath.
// Depends on srsw_pkg, srsw_ctrl and srsw_dp.
//
// Usage: req_ carries one command (send pass, ack, slide) per transfer;
// rsp_ returns one or more results, the final one flagged by last.
// csr_ writes window size, total segments and timeout; write only when idle.
// One command is handled at a time; req_ready is high only between commands.
// The slot memory has one registered read port, so each slot visit has a
// read state, then an execute/write state. A send pass visits the active
// slots and stops after 32 results. A slide counts the done slots at the
// front; if there are any, it copies the rest of the window down and
// clears its top. An ack inside the window reads, then writes its slot.
// Results leave through an output register, with one further result held
// pending so that last can be set; if rsp_ready is low the pass waits on
// the next transmission, or on the final result, until the output frees.
// Reset (synchronous) clears the window base, restores register defaults
// and marks every slot not-sent through per-slot valid bits, at once.
module selective_repeat_send_window_unit #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  srsw_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output srsw_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);

   srsw_pkg::cmd_type cmd;
   srsw_pkg::sts_type sts;

   srsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srsw_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/srsw_checker.sv =====
`timescale 1ns / 100ps
// Checker for the selective-repeat send window: mirrors slot state from req_ and csr_
// transfers and compares each rsp_ transfer field by field. Depends on srsw_pkg.
module srsw_checker
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fail_count,
   output int                   outstanding
);

   logic [1:0]  slot_st    [WINDOW_MAX];
   logic [31:0] slot_stamp [WINDOW_MAX];
   logic [31:0] win_base;
   logic [5:0]  cfg_window;
   logic [31:0] cfg_total;
   logic [15:0] cfg_timeout;
   rsp_type     due_results [$];
   rsp_type     want;
   int          errors = 0;
   int          s;

   function automatic int eff_window();
      int w;
      w = int'(cfg_window);
      if (w < 1) w = 1;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      return w;
   endfunction

   function automatic int live_slots();
      logic [31:0] left;
      int          w;
      w = eff_window();
      if (win_base >= cfg_total) return 0;
      left = cfg_total - win_base;
      return (left < 32'(w)) ? int'(left) : w;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [31:0] seq);
      rsp_type r;
      r.kind        = kind;
      r.seq_num     = seq;
      r.window_base = win_base;
      r.complete    = (win_base == cfg_total);
      r.last        = 1'b0;
      due_results.push_back(r);
   endfunction

   function automatic void window_step(req_type r);
      int          n, w, k, cnt, i;
      logic [32:0] top;
      logic [31:0] age, idx;
      rsp_type     tail;
      cnt = 0;
      case (r.action)
         ACT_SEND: begin
            n = live_slots();
            for (i = 0; i < n && cnt < MAX_RESULTS; i++) begin
               if (slot_st[i] == ST_NOT_SENT) begin
                  slot_st[i]    = ST_AWAITING;
                  slot_stamp[i] = r.now_ms;
                  push_result(KIND_NEW, win_base + 32'(i));
                  cnt++;
               end else if (slot_st[i] == ST_AWAITING) begin
                  age = r.now_ms - slot_stamp[i];
                  if (age > {16'd0, cfg_timeout}) begin
                     slot_stamp[i] = r.now_ms;
                     push_result(KIND_RESEND, win_base + 32'(i));
                     cnt++;
                  end
               end
            end
         end
         ACT_ACK: begin
            top = {1'b0, win_base} + 33'(eff_window());
            if (r.pkt_type == ACK_TYPE && r.ack_seq >= win_base && {1'b0, r.ack_seq} < top) begin
               idx = r.ack_seq - win_base;
               if (idx < 32'(WINDOW_MAX)) slot_st[idx] = ST_DONE;
            end
         end
         ACT_SLIDE: begin
            n = live_slots();
            w = eff_window();
            k = 0;
            while (k < n && slot_st[k] == ST_DONE) k++;
            if (k > 0) begin
               for (i = k; i < w; i++) begin
                  slot_st[i-k]    = slot_st[i];
                  slot_stamp[i-k] = slot_stamp[i];
               end
               for (i = w - k; i < w; i++) begin
                  slot_st[i]    = ST_NOT_SENT;
                  slot_stamp[i] = 32'd0;
               end
               win_base = win_base + 32'(k);
            end
         end
         default: ;
      endcase
      if (cnt == 0) push_result(KIND_STATUS, 32'd0);
      tail      = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0d, actual %0d", name, exp, act);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (s = 0; s < WINDOW_MAX; s++) begin
            slot_st[s]    = ST_NOT_SENT;
            slot_stamp[s] = 32'd0;
         end
         win_base    = 32'd0;
         cfg_window  = WINDOW_SIZE_RST;
         cfg_total   = 32'd0;
         cfg_timeout = TIMEOUT_MS_RST;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_SIZE:    cfg_window  = csr_wdata[5:0];
               CSR_TOTAL_SEGMENTS: cfg_total   = csr_wdata;
               CSR_TIMEOUT_MS:     cfg_timeout = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected transfer: kind %0d seq_num %0d window_base %0d",
                      rsp_data.kind, rsp_data.seq_num, rsp_data.window_base);
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
               check_field("seq_num", want.seq_num, rsp_data.seq_num);
               check_field("window_base", want.window_base, rsp_data.window_base);
               check_field("complete", 32'(want.complete), 32'(rsp_data.complete));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
         if (req_valid && req_ready) window_step(req_data);
      end
      fail_count  <= errors;
      outstanding <= due_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Send window testbench top: clock, reset, stimulus with idling phases, and verdict.
// Depends on srsw_pkg, srsw_checker and selective_repeat_send_window_unit.
module tb_top;
   import srsw_pkg::*;

   localparam logic [1:0] ACT_NONE     = 2'd3;
   localparam int         LIMIT        = 1_000_000;
   localparam int         SETTLE       = 160;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         RANDOM_ITEMS = 250;
   localparam int         PHASE_ITEMS  = 32;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_type              req_data  = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   int                   fail_count;
   int                   outstanding;

   int          tx_idle_pct  = 0;
   int          rx_stall_pct = 0;
   int          hold_asks    = 0;
   int          hold_done    = 0;
   int          hold_left    = 0;
   int          cycles       = 0;
   int          sent_items   = 0;
   logic [31:0] seen_base    = 32'd0;
   logic [31:0] now_t;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   selective_repeat_send_window_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srsw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_asks != hold_done) begin
         hold_done <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
      if (rsp_valid && rsp_ready) seen_base <= rsp_data.window_base;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic put_req(input logic [1:0] act, input logic [1:0] ptype,
                          input logic [31:0] seq, input logic [31:0] now);
      req_type r;
      r.action   = act;
      r.pkt_type = ptype;
      r.ack_seq  = seq;
      r.now_ms   = now;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic drain(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one pass of a normal transfer: send, maybe resend near the timeout, acks, maybe a random command, slide
   task automatic window_round(input int w_eff, input logic [15:0] tmo);
      logic [31:0] b;
      int          na, j;
      drain(0);
      b = seen_base;
      put_req(ACT_SEND, 2'($urandom), $urandom, now_t);
      if ($urandom_range(2) == 0)
         put_req(ACT_SEND, 2'($urandom), $urandom, now_t + tmo + $urandom_range(2) - 1);
      na = $urandom_range((w_eff < 6) ? w_eff : 6);
      for (j = 0; j < na; j++)
         put_req(ACT_ACK, ($urandom_range(9) == 0) ? 2'($urandom_range(2)) : ACK_TYPE,
                 b + j, $urandom);
      repeat ($urandom_range(2))
         put_req(ACT_ACK, ACK_TYPE, b + $urandom_range(w_eff), $urandom);
      if ($urandom_range(9) == 0)
         put_req(ACT_ACK, ACK_TYPE, b - 1 - $urandom_range(3), $urandom);
      if ($urandom_range(6) == 0)
         put_req(2'($urandom), 2'($urandom), $urandom, $urandom);
      put_req(ACT_SLIDE, 2'($urandom), $urandom, $urandom);
      now_t = now_t + $urandom_range(32'(tmo) + 64);
   endtask

   initial begin
      int          p, target, phase_end, wval, w_eff;
      logic [15:0] tmo;
      logic [31:0] total;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults, no segments: status only, ack past total, empty slide
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd0);
      put_req(ACT_NONE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      put_req(ACT_ACK, ACK_TYPE, 32'd0, 32'd0);
      put_req(ACT_SLIDE, 2'd0, 32'd0, 32'd0);
      drain(SETTLE);

      // oversized window, zero timeout, stamps across the 32-bit wrap
      cfg_write(CSR_TOTAL_SEGMENTS, 32'd40);
      cfg_write(CSR_WINDOW_SIZE, 32'd63);
      cfg_write(CSR_TIMEOUT_MS, 32'd0);
      put_req(ACT_SEND, 2'd3, 32'd0, 32'hFFFF_FFF0);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'hFFFF_FFF0);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd5);
      put_req(ACT_ACK, ACK_TYPE, 32'd31, 32'd0);
      put_req(ACT_ACK, ACK_TYPE, 32'd32, 32'd0);
      put_req(ACT_ACK, 2'd2, 32'd1, 32'd0);
      put_req(ACT_ACK, ACK_TYPE, 32'hFFFF_FFFF, 32'd0);
      put_req(ACT_SLIDE, 2'd0, 32'd0, 32'd0);
      put_req(ACT_ACK, ACK_TYPE, 32'd1, 32'd0);
      put_req(ACT_ACK, ACK_TYPE, 32'd0, 32'd0);
      put_req(ACT_SLIDE, 2'd0, 32'd0, 32'd0);
      drain(SETTLE);

      // zero window acts as one; age equal to the maximum timeout is not resent
      cfg_write(CSR_WINDOW_SIZE, 32'd0);
      cfg_write(CSR_TIMEOUT_MS, 32'd65535);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd1000);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd65540);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd65541);
      put_req(ACT_ACK, ACK_TYPE, 32'd2, 32'd0);
      put_req(ACT_SLIDE, 2'd0, 32'd0, 32'd0);
      put_req(ACT_SEND, 2'd0, 32'd0, 32'd70000);

      now_t  = $urandom;
      target = sent_items + RANDOM_ITEMS;
      p      = 0;
      while (sent_items < target) begin
         drain(SETTLE);
         case (p % 5)
            0:       wval = 32;
            1:       wval = 1;
            2:       wval = 0;
            3:       wval = 33 + $urandom_range(30);
            default: wval = $urandom_range(31, 2);
         endcase
         w_eff = (wval < 1) ? 1 : (wval > 32) ? 32 : wval;
         case (p % 3)
            0:       tmo = 16'($urandom_range(400, 40));
            1:       tmo = 16'd0;
            default: tmo = 16'hFFFF;
         endcase
         case (p % 7)
            6:       total = 32'hFFFF_FFFF;
            5:       total = seen_base;
            default: total = seen_base + $urandom_range(48, 4);
         endcase
         cfg_write(CSR_WINDOW_SIZE, {26'($urandom), 6'(wval)});
         cfg_write(CSR_TOTAL_SEGMENTS, total);
         cfg_write(CSR_TIMEOUT_MS, {16'($urandom), tmo});
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
         endcase
         if (p == 2) hold_asks++;
         phase_end = sent_items + PHASE_ITEMS;
         while (sent_items < phase_end) window_round(w_eff, tmo);
         p++;
      end

      drain(SETTLE);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
